[hw/rtl/mpps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Motor pulse pattern sequencer package
// Phase, pattern and status codes, duration limits and field widths.
// ----------------------------------------------------------------------------
package mpps_pkg;

  localparam int unsigned PatternW  = 3;
  localparam int unsigned DurationW = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned TicksW    = 13;
  localparam int unsigned SecondW   = 11;

  // sequence phases
  localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_FIRST = 2'd1;
  localparam logic [PhaseW-1:0] PH_GAP   = 2'd2;
  localparam logic [PhaseW-1:0] PH_LAST  = 2'd3;

  // pattern codes
  localparam logic [PatternW-1:0] PAT_OFF    = 3'd0;
  localparam logic [PatternW-1:0] PAT_SHORT  = 3'd1;
  localparam logic [PatternW-1:0] PAT_DOUBLE = 3'd2;
  localparam logic [PatternW-1:0] PAT_LONG   = 3'd3;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_BADARG   = 2'd1;
  localparam logic [StatusW-1:0] ST_BADSTATE = 2'd2;
  localparam logic [StatusW-1:0] ST_BUSY     = 2'd3;

  // accepted durations in ms, bounds included
  localparam logic [DurationW-1:0] SHORT_MIN  = 16'd100;
  localparam logic [DurationW-1:0] SHORT_MAX  = 16'd1000;
  localparam logic [DurationW-1:0] DOUBLE_MIN = 16'd200;
  localparam logic [DurationW-1:0] DOUBLE_MAX = 16'd2000;
  localparam logic [DurationW-1:0] LONG_MIN   = 16'd1000;
  localparam logic [DurationW-1:0] LONG_MAX   = 16'd5000;

  typedef struct packed {
    logic                 sequence_done;
    logic                 busy_res;
    logic [StatusW-1:0]   status;
    logic                 motor_on;
  } result_t;

endpackage : mpps_pkg
`default_nettype wire

[hw/rtl/motor_pulse_pattern_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Motor pulse pattern sequencer
// Drives one active-high motor line from pattern commands and 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per transaction. tuser selects the kind:
//   0 = one millisecond tick, 1 = pattern command (pattern and duration in
//   tdata). Every item gives exactly one result transaction on the master
//   stream: motor level, status, busy flag and end-of-sequence flag.
//   The result is registered on the edge that accepts the item. Throughput
//   is one item per cycle while the receiver takes results; sequencer state
//   updates in a single pass of compare/decrement logic between its registers.
//   The output register is the only buffer: while a result waits and the
//   receiver holds m_axis_tready low, s_axis_tready is low too; once the
//   receiver takes the result a new item is accepted in the same cycle.
//   cfg_we_i/cfg_wdata_i write the driver-ready bit; write it while idle.
//   Reset leaves the motor off, the sequencer idle, driver-ready clear and
//   no result pending.
// ----------------------------------------------------------------------------
module motor_pulse_pattern_sequencer
  import mpps_pkg::*;
#(
  parameter int unsigned GAP_TICKS = 200
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,   // driver_ready
  // slave stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [2:0] pattern, [18:3] duration, zero pad
  input  wire logic        s_axis_tuser,  // func
  // master stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata   // [0] motor_on, [2:1] status,
                                          // [3] busy_res, [4] sequence_done
);

  logic                  ready_q;
  logic [PhaseW-1:0]     phase_q, phase_d;
  logic [TicksW-1:0]     ticks_q, ticks_d;
  logic [SecondW-1:0]    second_q, second_d;
  logic                  motor_q, motor_d;
  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic                  accept;
  logic [PatternW-1:0]   pattern;
  logic [DurationW-1:0]  duration;
  logic                  arg_ok;
  logic [StatusW-1:0]    status;
  logic                  done;
  logic [TicksW-1:0]     ticks_dec;
  logic [SecondW-1:0]    half;

  assign pattern  = s_axis_tdata[2:0];
  assign duration = s_axis_tdata[18:3];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (pattern)
      PAT_OFF:    arg_ok = (duration == '0);
      PAT_SHORT:  arg_ok = (duration >= SHORT_MIN) && (duration <= SHORT_MAX);
      PAT_DOUBLE: arg_ok = (duration >= DOUBLE_MIN) && (duration <= DOUBLE_MAX);
      PAT_LONG:   arg_ok = (duration >= LONG_MIN) && (duration <= LONG_MAX);
      default:    arg_ok = 1'b0;
    endcase
  end

  // duration of a double pattern is at most 2000, so 11 bits hold it
  assign half      = {1'b0, duration[SecondW-1:1]};
  assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : '0;

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    second_d = second_q;
    motor_d  = motor_q;
    status   = ST_OK;
    done     = 1'b0;
    if (s_axis_tuser) begin
      if (!arg_ok) begin
        status = ST_BADARG;
      end else if (!ready_q) begin
        status = ST_BADSTATE;
      end else if (phase_q != PH_IDLE) begin
        status = ST_BUSY;
      end else if (pattern == PAT_OFF) begin
        motor_d = 1'b0;
      end else if (pattern == PAT_DOUBLE) begin
        ticks_d  = TicksW'(half);
        second_d = duration[SecondW-1:0] - half;
        phase_d  = PH_FIRST;
        motor_d  = 1'b1;
      end else begin
        ticks_d = duration[TicksW-1:0];
        phase_d = PH_LAST;
        motor_d = 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      ticks_d = ticks_dec;
      if (ticks_dec == '0) begin
        unique case (phase_q)
          PH_FIRST: begin
            motor_d = 1'b0;
            ticks_d = TicksW'(GAP_TICKS);
            phase_d = PH_GAP;
          end
          PH_GAP: begin
            motor_d = 1'b1;
            ticks_d = TicksW'(second_q);
            phase_d = PH_LAST;
          end
          default: begin
            motor_d = 1'b0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_d.motor_on      = motor_d;
    res_d.status        = status;
    res_d.busy_res      = (phase_d != PH_IDLE);
    res_d.sequence_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= 1'b0;
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      second_q    <= '0;
      motor_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ready_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        ticks_q     <= ticks_d;
        second_q    <= second_d;
        motor_q     <= motor_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

`ifndef SYNTHESIS
  // motor level follows the phase: on in pulses, off in the gap and when idle
  a_motor_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE || phase_q == PH_GAP) |-> !motor_q)
    else $error("motor on outside a pulse");

  a_motor_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIRST || phase_q == PH_LAST) |-> motor_q)
    else $error("motor off during a pulse");

  // a running phase always has ticks to count down
  a_ticks_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (ticks_q != '0))
    else $error("running phase with zero ticks");

  // a rejected command leaves the sequencer untouched
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser && status != ST_OK)
      |=> ($stable(phase_q) && $stable(ticks_q) && $stable(motor_q)))
    else $error("rejected command changed state");

  // end of sequence is only reported by a tick that leaves the block idle
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.sequence_done)
      |-> (!res_q.busy_res && !res_q.motor_on && res_q.status == ST_OK))
    else $error("inconsistent end-of-sequence result");
`endif

endmodule : motor_pulse_pattern_sequencer
`default_nettype wire

[dv/motor_pulse_pattern_sequencer_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Motor pulse pattern sequencer testbench
// Drives ticks and pattern commands over the input stream and checks every
// result transaction against a cycle-free model of the sequencer. The model
// tracks phase, remaining ticks, the second DOUBLE pulse and the driver-ready
// bit. The run covers a directed sweep of argument limits and error ordering,
// a full SHORT run and an odd-length DOUBLE run, then random traffic under
// three flow-control regimes with ready toggles and output hold-offs, and
// ends by loading the longest LONG pulse.
// ----------------------------------------------------------------------------
module motor_pulse_pattern_sequencer_test;
  import mpps_pkg::*;

  localparam int unsigned GapTicks   = 200;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxPrinted = 30;

  localparam bit FuncTick = 1'b0;
  localparam bit FuncCmd  = 1'b1;

  // pattern codes with no meaning in the block
  localparam logic [PatternW-1:0] PatFirstUnused = 3'd4;
  localparam logic [PatternW-1:0] PatLastUnused  = 3'd7;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [7:0]  m_axis_tdata;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned ready_writes  = 0;

  motor_pulse_pattern_sequencer #(
    .GAP_TICKS(GapTicks)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Sequencer model plus the queue of results it has predicted.
  class pulse_tracker;
    bit                  ready;
    logic [PhaseW-1:0]   phase;
    logic [TicksW-1:0]   ticks_left;
    logic [SecondW-1:0]  second_len;
    bit                  motor;
    result_t             expected_results[$];
    int unsigned         errors;
    int unsigned         results_checked;
    int unsigned         items_seen;
    int unsigned         ticks_seen;
    int unsigned         seqs_done;
    int unsigned         status_seen[4];

    function new();
      ready      = 1'b0;
      phase      = PH_IDLE;
      ticks_left = '0;
      second_len = '0;
      motor      = 1'b0;
      errors          = 0;
      results_checked = 0;
      items_seen      = 0;
      ticks_seen      = 0;
      seqs_done       = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit arg_ok(logic [PatternW-1:0] pat, logic [DurationW-1:0] dur);
      case (pat)
        PAT_OFF:    return dur == '0;
        PAT_SHORT:  return dur >= SHORT_MIN && dur <= SHORT_MAX;
        PAT_DOUBLE: return dur >= DOUBLE_MIN && dur <= DOUBLE_MAX;
        PAT_LONG:   return dur >= LONG_MIN && dur <= LONG_MAX;
        default:    return 1'b0;
      endcase
    endfunction

    // Called on each accepted input transaction.
    function void predict_item(bit is_cmd, logic [PatternW-1:0] pat,
                               logic [DurationW-1:0] dur);
      result_t              r;
      logic [DurationW-1:0] first;
      r = '0;
      items_seen++;
      if (is_cmd) begin
        // argument first, then ready, then busy; a rejection changes nothing
        if (!arg_ok(pat, dur)) begin
          r.status = ST_BADARG;
        end else if (!ready) begin
          r.status = ST_BADSTATE;
        end else if (phase != PH_IDLE) begin
          r.status = ST_BUSY;
        end else if (pat == PAT_OFF) begin
          motor = 1'b0;
        end else if (pat == PAT_DOUBLE) begin
          first      = dur >> 1;
          second_len = SecondW'(dur - first);
          ticks_left = TicksW'(first);
          phase      = PH_FIRST;
          motor      = 1'b1;
        end else begin
          ticks_left = TicksW'(dur);
          phase      = PH_LAST;
          motor      = 1'b1;
        end
        status_seen[r.status]++;
      end else begin
        ticks_seen++;
        if (phase != PH_IDLE) begin
          if (ticks_left != '0) ticks_left--;
          if (ticks_left == '0) begin
            case (phase)
              PH_FIRST: begin
                motor      = 1'b0;
                ticks_left = TicksW'(GapTicks);
                phase      = PH_GAP;
              end
              PH_GAP: begin
                motor      = 1'b1;
                ticks_left = TicksW'(second_len);
                phase      = PH_LAST;
              end
              default: begin
                motor           = 1'b0;
                phase           = PH_IDLE;
                r.sequence_done = 1'b1;
                seqs_done++;
              end
            endcase
          end
        end
      end
      r.motor_on = motor;
      r.busy_res = (phase != PH_IDLE);
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors <= MaxPrinted)
        $display("[%0t] result %0d: %s got %0h, expected %0h",
                 $time, results_checked, what, got, want);
    endtask

    task check_result(logic [7:0] data);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("transaction with nothing expected", data, '0);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (data[0] !== want.motor_on)
        report_mismatch("motor_on", 8'(data[0]), 8'(want.motor_on));
      if (data[2:1] !== want.status)
        report_mismatch("status", 8'(data[2:1]), 8'(want.status));
      if (data[3] !== want.busy_res)
        report_mismatch("busy_res", 8'(data[3]), 8'(want.busy_res));
      if (data[4] !== want.sequence_done)
        report_mismatch("sequence_done", 8'(data[4]), 8'(want.sequence_done));
      if (data[7:5] !== 3'b000)
        report_mismatch("pad bits", 8'(data[7:5]), '0);
    endtask
  endclass

  pulse_tracker tracker = new();

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  task automatic send_item(bit is_cmd, logic [PatternW-1:0] pat,
                           logic [DurationW-1:0] dur);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = is_cmd;
    s_axis_tdata  = {5'b0, dur, pat};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.predict_item(is_cmd, pat, dur);
  endtask

  // tdata content of a tick is ignored, so fill it with junk
  task automatic send_tick();
    send_item(FuncTick, PatternW'($urandom), DurationW'($urandom));
  endtask

  task automatic run_out();
    while (tracker.phase != PH_IDLE) send_tick();
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_ready(bit value);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tracker.ready = value;
    ready_writes++;
  endtask

  // Durations lean towards the lower bound to keep runs short.
  function automatic logic [DurationW-1:0] pick_valid(logic [PatternW-1:0] pat);
    int unsigned lo, hi, r;
    case (pat)
      PAT_SHORT:  begin lo = 32'(SHORT_MIN);  hi = 32'(SHORT_MAX);        end
      PAT_DOUBLE: begin lo = 32'(DOUBLE_MIN); hi = 32'(DOUBLE_MAX);       end
      PAT_LONG:   begin lo = 32'(LONG_MIN);   hi = 32'(LONG_MIN) + 200;   end
      default:    return '0;
    endcase
    r = $urandom_range(99);
    if (r < 60)      return DurationW'(lo + $urandom_range(15));
    else if (r < 75) return DurationW'(lo);
    else if (r < 85) return DurationW'(hi);
    else             return DurationW'($urandom_range(hi, lo));
  endfunction

  function automatic logic [DurationW-1:0] pick_invalid(logic [PatternW-1:0] pat);
    int unsigned lo, hi, r;
    case (pat)
      PAT_OFF:    return DurationW'($urandom_range(65535, 1));
      PAT_SHORT:  begin lo = 32'(SHORT_MIN);  hi = 32'(SHORT_MAX);  end
      PAT_DOUBLE: begin lo = 32'(DOUBLE_MIN); hi = 32'(DOUBLE_MAX); end
      PAT_LONG:   begin lo = 32'(LONG_MIN);   hi = 32'(LONG_MAX);   end
      default:    return DurationW'($urandom);
    endcase
    r = $urandom_range(99);
    if (r < 25)      return DurationW'(lo - 1);
    else if (r < 50) return DurationW'(hi + 1);
    else if (r < 75) return DurationW'($urandom_range(lo - 1, 0));
    else             return DurationW'($urandom_range(65535, hi + 1));
  endfunction

  // any pattern; valid arguments only when allowed, so that an idle block
  // is not handed a LONG or DOUBLE run that would eat the item budget
  task automatic send_random_cmd(bit allow_valid);
    logic [PatternW-1:0]  pat;
    logic [DurationW-1:0] dur;
    pat = PatternW'($urandom);
    if (allow_valid && pat <= PAT_LONG && $urandom_range(1)) dur = pick_valid(pat);
    else                                                     dur = pick_invalid(pat);
    send_item(FuncCmd, pat, dur);
  endtask

  // While a sequence runs: mostly ticks, with stray commands and the odd
  // ready toggle. While idle: ticks, bad commands, ready writes, OFF or a short pulse.
  task automatic send_random_item();
    int unsigned         r;
    logic [PatternW-1:0] pat;
    r = $urandom_range(999);
    if (tracker.phase != PH_IDLE) begin
      if (r < 3)       write_ready(!tracker.ready);
      else if (r < 20) send_random_cmd(1'b1);
      else             send_tick();
    end else if (!tracker.ready && r < 700) begin
      write_ready(1'b1);
    end else if (r < 300) begin
      send_tick();
    end else if (r < 600) begin
      send_random_cmd(1'b0);
    end else if (r < 640) begin
      write_ready(1'b0);
    end else begin
      pat = ($urandom_range(3) == 0) ? PAT_OFF : PAT_SHORT;
      send_item(FuncCmd, pat, pick_valid(pat));
    end
  endtask

  initial begin
    int unsigned phase_start;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // not ready yet: argument errors still win over the ready check
    send_tick();
    send_item(FuncCmd, PAT_OFF, 16'd0);
    send_item(FuncCmd, PAT_SHORT, SHORT_MIN);
    send_item(FuncCmd, PatLastUnused, 16'hFFFF);
    send_item(FuncCmd, PAT_OFF, 16'd1);
    write_ready(1'b1);
    send_item(FuncCmd, PAT_OFF, 16'd0);
    send_item(FuncCmd, PAT_SHORT, DurationW'(SHORT_MIN - 1));
    send_item(FuncCmd, PAT_SHORT, DurationW'(SHORT_MAX + 1));
    send_item(FuncCmd, PAT_DOUBLE, DurationW'(DOUBLE_MIN - 1));
    send_item(FuncCmd, PAT_DOUBLE, DurationW'(DOUBLE_MAX + 1));
    send_item(FuncCmd, PAT_LONG, DurationW'(LONG_MIN - 1));
    send_item(FuncCmd, PAT_LONG, DurationW'(LONG_MAX + 1));
    send_item(FuncCmd, PatFirstUnused, 16'd500);
    send_item(FuncCmd, PatternW'(PatFirstUnused + 1), 16'd1000);
    send_item(FuncCmd, PatternW'(PatLastUnused - 1), 16'd0);
    send_item(FuncCmd, PAT_SHORT, SHORT_MIN);
    // running: OFF cannot abort, but a bad argument is still a bad argument
    send_item(FuncCmd, PAT_OFF, 16'd0);
    send_item(FuncCmd, PAT_LONG, LONG_MAX);
    send_item(FuncCmd, PAT_DOUBLE, 16'd0);
    send_tick();
    run_out();

    // odd DOUBLE for the rounding; its ticks ride the random traffic below
    send_item(FuncCmd, PAT_DOUBLE, DurationW'(DOUBLE_MIN + 1));

    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0:       begin src_idle_pct = 8;  sink_idle_pct = 45; end
        1:       begin src_idle_pct = 45; sink_idle_pct = 8;  end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      // long output hold-off while input keeps coming, to back up the block
      @(posedge clk_i);
      hold_left = HoldCycles;
      phase_start = tracker.items_seen;
      while (tracker.items_seen - phase_start < PhaseItems) send_random_item();
    end

    // load the widest count; the run ends with this pulse still going
    run_out();
    if (!tracker.ready) write_ready(1'b1);
    send_item(FuncCmd, PAT_LONG, LONG_MAX);
    repeat (8) send_tick();

    drain();
    repeat (5) @(posedge clk_i);
    $display("Checked %0d results: %0d ticks, %0d sequences completed, %0d ready writes",
             tracker.results_checked, tracker.ticks_seen, tracker.seqs_done, ready_writes);
    $display("Commands: %0d ok, %0d bad argument, %0d not ready, %0d busy",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_BADARG],
             tracker.status_seen[ST_BADSTATE], tracker.status_seen[ST_BUSY]);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #250_000;
    $display("Timed out with %0d results outstanding", tracker.expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule : motor_pulse_pattern_sequencer_test
`default_nettype wire
